>>> hdl/htfd_pkg.sv
// ----------------------------------------------------------------------------
// htfd_pkg
// Shared types, constants and the CRC-8 step of the humidity/temperature
// frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package htfd_pkg;

  // CRC-8, polynomial x^8 + x^5 + x^4 + 1, MSB first, no final xor
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Scaling spans and offsets, in hundredths
  localparam logic [14:0] TEMP_SPAN = 15'd17500;
  localparam logic [14:0] HUM_SPAN  = 15'd12500;
  localparam logic signed [14:0] TEMP_OFFSET = -15'sd4500;
  localparam logic signed [14:0] HUM_OFFSET  = -15'sd600;

  // Half of the divisor 65535, rounded down, for round-to-nearest
  localparam logic [31:0] ROUND_BIAS = 32'd32767;

  // Position of the next byte in the six-byte reply
  typedef enum logic [2:0] {
    POS_T_MSB = 3'd0,
    POS_T_LSB = 3'd1,
    POS_T_CRC = 3'd2,
    POS_H_MSB = 3'd3,
    POS_H_LSB = 3'd4,
    POS_H_CRC = 3'd5
  } byte_pos_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TEMP_CRC = 2'd1,
    STATUS_HUM_CRC  = 2'd2
  } frame_status_t;

  // Checked frame handed from the frame tracker to the scaler
  typedef struct packed {
    logic [15:0]   temp_word;
    logic [15:0]   hum_word;
    frame_status_t status;
  } frame_res_t;

  // Finished result handed from the scaler to the top level
  typedef struct packed {
    logic signed [14:0] temperature_centi;
    logic signed [14:0] humidity_centi;
    logic [15:0]        temp_word;
    logic [15:0]        hum_word;
    frame_status_t      status;
  } sensor_out_t;

  // Fold one byte into the CRC, eight shift steps
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hdl/htfd_frame.sv
// ----------------------------------------------------------------------------
// htfd_frame
// Input register, byte position tracking and CRC checking; emits one checked
// frame after the sixth byte.
// ----------------------------------------------------------------------------
`default_nettype none

module htfd_frame
  import htfd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       up_valid,
  output logic            up_ready,
  input  wire logic [7:0] up_byte,
  input  wire logic       up_start,
  output logic            dn_valid,
  input  wire logic       dn_ready,
  output frame_res_t      dn_data
);

  logic       s0_valid_r;
  logic [7:0] s0_byte_r;
  logic       s0_start_r;

  byte_pos_t  pos_r, pos_nxt, pos_eff;
  logic [7:0] crc_r, crc_nxt;
  logic [15:0] temp_r, temp_nxt;
  logic [15:0] hum_r, hum_nxt;
  logic       tok_r, tok_nxt;
  logic       hum_ok;

  logic       res_valid_r, res_valid_nxt;
  frame_res_t res_r, res_nxt;

  logic       is_last;
  logic       res_ready;
  logic       s0_fire;

  // A start flag forces byte zero of a new frame
  assign pos_eff   = s0_start_r ? POS_T_MSB : pos_r;
  assign is_last   = (pos_eff == POS_H_CRC);
  assign res_ready = !res_valid_r || dn_ready;
  assign s0_fire   = s0_valid_r && (!is_last || res_ready);
  assign up_ready  = !s0_valid_r || s0_fire;
  assign hum_ok    = (crc_r == s0_byte_r);

  // Capture the incoming transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (up_ready) begin
      s0_valid_r <= up_valid;
    end
    if (up_valid && up_ready) begin
      s0_byte_r  <= up_byte;
      s0_start_r <= up_start;
    end
  end

  // Next byte position
  always_comb begin
    pos_nxt = pos_r;
    if (s0_fire) begin
      case (pos_eff)
        POS_T_MSB: pos_nxt = POS_T_LSB;
        POS_T_LSB: pos_nxt = POS_T_CRC;
        POS_T_CRC: pos_nxt = POS_H_MSB;
        POS_H_MSB: pos_nxt = POS_H_LSB;
        POS_H_LSB: pos_nxt = POS_H_CRC;
        default:   pos_nxt = POS_T_MSB;
      endcase
    end
  end

  // Per-byte updates of CRC, words and the frame result
  always_comb begin
    crc_nxt  = crc_r;
    temp_nxt = temp_r;
    hum_nxt  = hum_r;
    tok_nxt  = tok_r;
    res_nxt  = res_r;
    if (s0_fire) begin
      case (pos_eff)
        POS_T_MSB: begin
          crc_nxt  = crc8_update(CRC_INIT, s0_byte_r);
          temp_nxt = {s0_byte_r, temp_r[7:0]};
        end
        POS_T_LSB: begin
          crc_nxt  = crc8_update(crc_r, s0_byte_r);
          temp_nxt = {temp_r[15:8], s0_byte_r};
        end
        POS_T_CRC: begin
          tok_nxt = (crc_r == s0_byte_r);
          crc_nxt = CRC_INIT;
        end
        POS_H_MSB: begin
          crc_nxt = crc8_update(CRC_INIT, s0_byte_r);
          hum_nxt = {s0_byte_r, hum_r[7:0]};
        end
        POS_H_LSB: begin
          crc_nxt = crc8_update(crc_r, s0_byte_r);
          hum_nxt = {hum_r[15:8], s0_byte_r};
        end
        default: begin
          crc_nxt           = CRC_INIT;
          res_nxt.temp_word = temp_r;
          res_nxt.hum_word  = hum_r;
          if (!tok_r) begin
            res_nxt.status = STATUS_TEMP_CRC;
          end else if (!hum_ok) begin
            res_nxt.status = STATUS_HUM_CRC;
          end else begin
            res_nxt.status = STATUS_OK;
          end
        end
      endcase
    end
  end

  // Result register: load on the last byte, drop once taken
  always_comb begin
    if (s0_fire && is_last) begin
      res_valid_nxt = 1'b1;
    end else if (dn_ready) begin
      res_valid_nxt = 1'b0;
    end else begin
      res_valid_nxt = res_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_T_MSB;
      crc_r       <= CRC_INIT;
      res_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      res_valid_r <= res_valid_nxt;
    end
    temp_r <= temp_nxt;
    hum_r  <= hum_nxt;
    tok_r  <= tok_nxt;
    res_r  <= res_nxt;
  end

  assign dn_valid = res_valid_r;
  assign dn_data  = res_r;

`ifndef SYNTHESIS
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s0_fire && is_last |=> res_valid_r)
    else $error("last byte did not produce a frame result");

  a_last_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    s0_fire && is_last |=> (pos_r == POS_T_MSB) && (crc_r == CRC_INIT))
    else $error("frame position or CRC not rewound after last byte");

  a_crc_byte_resets: assert property (@(posedge clk) disable iff (!rst_n)
    s0_fire && (pos_eff == POS_T_CRC) |=> (crc_r == CRC_INIT) && (pos_r == POS_H_MSB))
    else $error("CRC not restarted after temperature check byte");
`endif

endmodule

`default_nettype wire

>>> hdl/htfd_scale.sv
// ----------------------------------------------------------------------------
// htfd_scale
// Two-stage conversion of the raw words to hundredths: a product stage and a
// divide-by-65535 with rounding, offset and error zeroing.
// ----------------------------------------------------------------------------
`default_nettype none

module htfd_scale
  import htfd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        up_valid,
  output logic             up_ready,
  input  wire frame_res_t  up_data,
  output logic             dn_valid,
  input  wire logic        dn_ready,
  output sensor_out_t      dn_data
);

  logic        a_valid_r;
  frame_res_t  a_res_r;
  logic [30:0] a_ptemp_r, a_ptemp_nxt;
  logic [30:0] a_phum_r, a_phum_nxt;
  logic        a_ready;

  logic        b_valid_r;
  sensor_out_t b_out_r, b_out_nxt;

  // floor((p + 32767) / 65535) via m + (m >> 16) + 1, exact for this range
  function automatic logic [14:0] div_round(input logic [30:0] p);
    logic [31:0] m;
    logic [31:0] s;
    m = {1'b0, p} + ROUND_BIAS;
    s = m + {16'd0, m[31:16]} + 32'd1;
    return s[30:16];
  endfunction

  assign a_ready  = !b_valid_r || dn_ready;
  assign up_ready = !a_valid_r || a_ready;

  // Products of span and raw word
  assign a_ptemp_nxt = 31'(TEMP_SPAN) * 31'(up_data.temp_word);
  assign a_phum_nxt  = 31'(HUM_SPAN) * 31'(up_data.hum_word);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (up_ready) begin
      a_valid_r <= up_valid;
    end
    if (up_valid && up_ready) begin
      a_res_r   <= up_data;
      a_ptemp_r <= a_ptemp_nxt;
      a_phum_r  <= a_phum_nxt;
    end
  end

  // Divide, round, offset; zero both values on any CRC error
  always_comb begin
    b_out_nxt.temp_word = a_res_r.temp_word;
    b_out_nxt.hum_word  = a_res_r.hum_word;
    b_out_nxt.status    = a_res_r.status;
    if (a_res_r.status == STATUS_OK) begin
      b_out_nxt.temperature_centi = TEMP_OFFSET + $signed(div_round(a_ptemp_r));
      b_out_nxt.humidity_centi    = HUM_OFFSET + $signed(div_round(a_phum_r));
    end else begin
      b_out_nxt.temperature_centi = '0;
      b_out_nxt.humidity_centi    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (a_ready) begin
      b_valid_r <= a_valid_r;
    end
    if (a_valid_r && a_ready) begin
      b_out_r <= b_out_nxt;
    end
  end

  assign dn_valid = b_valid_r;
  assign dn_data  = b_out_r;

`ifndef SYNTHESIS
  a_error_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r && (b_out_r.status != STATUS_OK) |->
      (b_out_r.temperature_centi == 15'sd0) && (b_out_r.humidity_centi == 15'sd0))
    else $error("converted values not zero on CRC error");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r && (b_out_r.status == STATUS_OK) |->
      (b_out_r.temperature_centi >= TEMP_OFFSET) &&
      (b_out_r.temperature_centi <= 15'sd13000))
    else $error("temperature out of range");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r && !dn_ready |=> b_valid_r && $stable(b_out_r))
    else $error("result changed while stalled");
`endif

endmodule

`default_nettype wire

>>> hdl/humidity_temp_frame_decoder.sv
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder
// Six-byte humidity/temperature reply decoder with CRC-8 checks and scaling
// to hundredths.
// ----------------------------------------------------------------------------
// Feed the reply one byte per transaction: temperature MSB, LSB, CRC, then
// humidity MSB, LSB, CRC; set in_tuser on a byte to make it byte zero of a
// new frame. The block takes one byte every cycle and is fully pipelined
// (input register, frame/CRC register, product register, output register);
// a result moves through the frame/CRC, product and output registers after
// the sixth byte is accepted, and only output backpressure stalls the input.
// frame_status is 0 for a good frame, 1 for a temperature CRC mismatch (also
// when both fail), 2 for a humidity CRC mismatch; on any mismatch both
// converted values are zero while the raw words are still reported.
`default_nettype none

module humidity_temp_frame_decoder
  import htfd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire logic [0:0]  in_tuser,   // [0] frame_start
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // [14:0] temperature_centi, [29:15] humidity_centi,
                                       // [45:30] temp_word, [61:46] hum_word, [63:62] zero
  output logic [1:0]       out_tuser   // [1:0] frame_status
);

  logic        frm_valid;
  logic        frm_ready;
  frame_res_t  frm_data;
  sensor_out_t res;

  htfd_frame u_frame (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_byte  (in_tdata),
    .up_start (in_tuser[0]),
    .dn_valid (frm_valid),
    .dn_ready (frm_ready),
    .dn_data  (frm_data)
  );

  htfd_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (frm_valid),
    .up_ready (frm_ready),
    .up_data  (frm_data),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_data  (res)
  );

  // Pack the result fields, lowest field first
  assign out_tdata = {2'b00, res.hum_word, res.temp_word,
                      res.humidity_centi, res.temperature_centi};
  assign out_tuser = res.status;

endmodule

`default_nettype wire
